FILE: hw/rtl/blz_pkg.sv
// Shared types and constants for the backward LZ bit-stream unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none

package blz_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned DEF_WINDOW_DEPTH = 4096;
  localparam int unsigned DEF_OUT_LANES    = 8;

  // Result status codes.
  localparam logic [2:0] STAT_RUN  = 3'd0;
  localparam logic [2:0] STAT_OK   = 3'd1;
  localparam logic [2:0] STAT_BAD  = 3'd2;
  localparam logic [2:0] STAT_BND  = 3'd3;
  localparam logic [2:0] STAT_EXH  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_PACKED = 1'b0;
  localparam logic CFG_CAP    = 1'b1;

  localparam logic [31:0] CHUNK_MARK = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: hw/rtl/blz_ring.sv
// History window of the unpacker: single write port, one registered read port.
// Depends on blz_pkg for the byte type.
`default_nettype none

module blz_ring import blz_pkg::*; #(
  parameter int unsigned Depth = DEF_WINDOW_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire byte_t                    wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output byte_t                         rdata_o
);

  byte_t mem_q [Depth];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/backward_lz_bitstream_unpacker_core.sv
// Backward LZ bit-stream unpacker, top level. Uses blz_pkg and blz_ring.
// Words enter one per transfer; unpacked bytes leave in lane groups.
`default_nettype none

// After reset the block first clears its history window, one entry a cycle;
// configuration writes are taken during that time but no word is. Words are
// then taken in reverse file order: length word, check word, then bit chunks.
// The decoder consumes one bit of the current chunk per cycle while the output
// does not hold it, and raw bytes cost nothing beyond their own bits. A chunk
// word is accepted in S_WAIT, runs through the bit loop until the chunk is
// found empty, and is closed in S_FIN and S_END; the length and check words go
// from S_WAIT straight to S_FIN and S_END. Every byte of a back-copy passes
// through S_CPRD and S_CPWR because the window is read through a registered
// port and then written. The block takes no new word until the current one has
// been fully decoded, including any copy it started, and the last result of
// that word has been handed to the output register. Up to two copies of 256
// bytes can finish within one word, so a word's duration is set by the
// one-bit-per-cycle decode loop and the single window write port. Results carry
// up to OUT_LANES bytes, the earliest in lane zero; the final result of each
// word has last_of_run set and carries the stream status. Stalls on the output
// side simply hold the decoder.
module backward_lz_bitstream_unpacker_core import blz_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned OUT_LANES    = DEF_OUT_LANES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] word_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_of_run_o,
  output logic [2:0]       stream_status_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [3:0] LANES = 4'(OUT_LANES);

  // Main sequencer codes.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_BITS  = 3'd2;
  localparam logic [2:0] S_CPRD  = 3'd3;
  localparam logic [2:0] S_CPWR  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;

  // Command decoder codes.
  localparam logic [3:0] C_IDLE    = 4'd0;
  localparam logic [3:0] C_PFX0    = 4'd1;
  localparam logic [3:0] C_PFX1    = 4'd2;
  localparam logic [3:0] C_RAWLEN3 = 4'd3;
  localparam logic [3:0] C_OFF8    = 4'd4;
  localparam logic [3:0] C_RAWLEN8 = 4'd5;
  localparam logic [3:0] C_OFFSET  = 4'd6;
  localparam logic [3:0] C_LEN8    = 4'd7;
  localparam logic [3:0] C_RAW     = 4'd8;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   packed_q, cap_q;
  logic [32:0]   chunk_q, chunk_d;
  logic [31:0]   chk_q, chk_d;
  logic [31:0]   left_q, left_d;
  logic [1:0]    hdr_q, hdr_d;
  logic [29:0]   taken_q, taken_d;
  logic [3:0]    cmd_q, cmd_d;
  logic [11:0]   acc_q, acc_d;
  logic [3:0]    fbits_q, fbits_d;
  logic [8:0]    run_q, run_d;
  logic [11:0]   off_q, off_d;
  logic [63:0]   lbuf_q, lbuf_d;
  logic [3:0]    lanes_q, lanes_d;
  logic          frz_q, frz_d;
  logic [5:0]    rcnt_q, rcnt_d;
  logic [2:0]    stat_q, stat_d;

  logic          ov_q;
  logic [63:0]   ob_q;
  logic [3:0]    oc_q;
  logic          ol_q;
  logic [2:0]    os_q;

  logic          emit;
  logic [63:0]   emit_bytes;
  logic [3:0]    emit_cnt;
  logic          emit_last;
  logic          slot_free;
  logic          emit_need;
  logic          put_stall;
  logic          put_en;
  byte_t         put_val;

  logic          ring_we;
  logic [AW-1:0] ring_waddr, ring_raddr;
  byte_t         ring_wdata, ring_rdata;

  logic [31:0]   pos;
  logic [11:0]   acc_sh;
  logic [3:0]    fb_dec;
  logic          bit_b;
  logic          at_limit;
  logic          copy_bad;
  logic [8:0]    raw_n;

  assign slot_free = !ov_q || out_ready_i;
  // A full lane group waits until another byte arrives, so that the final one
  // of a word can still be marked as last.
  assign emit_need = (lanes_q == LANES) && !frz_q && (rcnt_q != 6'd63);
  assign put_stall = emit_need && !slot_free;

  assign pos      = left_q - 32'd1;
  assign acc_sh   = {acc_q[10:0], chunk_q[0]};
  assign fb_dec   = (fbits_q == 4'd0) ? 4'd0 : fbits_q - 4'd1;
  assign bit_b    = chunk_q[0];
  assign at_limit = taken_q >= packed_q[31:2];

  assign in_ready_o = (state_q == S_WAIT);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    chunk_d = chunk_q;
    chk_d   = chk_q;
    left_d  = left_q;
    hdr_d   = hdr_q;
    taken_d = taken_q;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    fbits_d = fbits_q;
    run_d   = run_q;
    off_d   = off_q;
    lbuf_d  = lbuf_q;
    lanes_d = lanes_q;
    frz_d   = frz_q;
    rcnt_d  = rcnt_q;
    stat_d  = stat_q;
    emit       = 1'b0;
    emit_bytes = lbuf_q;
    emit_cnt   = lanes_q;
    emit_last  = 1'b0;
    put_en     = 1'b0;
    put_val    = acc_sh[7:0];
    copy_bad   = 1'b0;
    raw_n      = 9'd0;
    ring_we    = 1'b0;
    ring_waddr = pos[AW-1:0];
    ring_wdata = acc_sh[7:0];
    ring_raddr = pos[AW-1:0] + AW'(off_q);

    unique case (state_q)
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_q;
        ring_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        if (in_valid_i) begin
          if (stat_q != STAT_RUN) begin
            state_d = S_END;
          end else if (at_limit) begin
            stat_d  = STAT_EXH;
            state_d = S_END;
          end else begin
            taken_d = taken_q + 30'd1;
            state_d = S_FIN;
            unique case (hdr_q)
              2'd0: begin
                left_d = word_in_i;
                hdr_d  = 2'd1;
              end
              2'd1: begin
                chk_d = word_in_i;
                hdr_d = 2'd2;
              end
              2'd2: begin
                chk_d   = chk_q ^ word_in_i;
                chunk_d = {1'b0, word_in_i};
                hdr_d   = 2'd3;
                if (left_q == 32'd0) begin
                  stat_d = ((chk_q ^ word_in_i) == 32'd0) ? STAT_OK : STAT_BAD;
                end else begin
                  state_d = S_BITS;
                end
              end
              default: begin
                chk_d   = chk_q ^ word_in_i;
                chunk_d = {1'b1, word_in_i};
                state_d = S_BITS;
              end
            endcase
          end
        end
      end

      S_BITS: begin
        if (stat_q != STAT_RUN || chunk_q[32:1] == 32'd0) begin
          state_d = S_FIN;
        end else if (!(cmd_q == C_RAW && fb_dec == 4'd0 && put_stall)) begin
          chunk_d = {1'b0, chunk_q[32:1]};
          case (cmd_q)
            C_IDLE: begin
              if (bit_b) begin
                cmd_d   = C_PFX1;
                acc_d   = '0;
                fbits_d = 4'd2;
              end else begin
                cmd_d = C_PFX0;
              end
            end
            C_PFX0: begin
              acc_d   = '0;
              cmd_d   = bit_b ? C_OFF8 : C_RAWLEN3;
              fbits_d = bit_b ? 4'd8 : 4'd3;
            end
            default: begin
              acc_d   = acc_sh;
              fbits_d = fb_dec;
              if (fb_dec == 4'd0) begin
                case (cmd_q)
                  C_PFX1: begin
                    acc_d   = '0;
                    fbits_d = 4'd8;
                    if (acc_sh == 12'd3) begin
                      cmd_d = C_RAWLEN8;
                    end else if (acc_sh < 12'd2) begin
                      run_d   = 9'(acc_sh) + 9'd3;
                      cmd_d   = C_OFFSET;
                      fbits_d = 4'(acc_sh) + 4'd9;
                    end else begin
                      cmd_d = C_LEN8;
                    end
                  end
                  C_RAWLEN3, C_RAWLEN8: begin
                    raw_n = (cmd_q == C_RAWLEN3) ? 9'(acc_sh[2:0]) + 9'd1
                                                 : 9'(acc_sh[7:0]) + 9'd9;
                    if (pos >= cap_q || {23'd0, raw_n} > left_q) begin
                      stat_d = STAT_BND;
                    end else begin
                      run_d   = raw_n;
                      cmd_d   = C_RAW;
                      acc_d   = '0;
                      fbits_d = 4'd8;
                    end
                  end
                  C_LEN8: begin
                    run_d   = 9'(acc_sh[7:0]) + 9'd1;
                    cmd_d   = C_OFFSET;
                    acc_d   = '0;
                    fbits_d = 4'd12;
                  end
                  C_OFF8, C_OFFSET: begin
                    raw_n    = (cmd_q == C_OFF8) ? 9'd2 : run_q;
                    copy_bad = ({1'b0, pos} + {21'd0, acc_sh}) >= {1'b0, cap_q}
                               || {23'd0, raw_n} > left_q;
                    run_d    = raw_n;
                    off_d    = acc_sh;
                    if (copy_bad) begin
                      stat_d = STAT_BND;
                    end else begin
                      state_d = S_CPRD;
                    end
                  end
                  C_RAW: begin
                    put_en  = 1'b1;
                    put_val = acc_sh[7:0];
                    run_d   = (run_q != 9'd0) ? run_q - 9'd1 : 9'd0;
                    if (run_d == 9'd0) begin
                      cmd_d = C_IDLE;
                      if (left_q == 32'd1) begin
                        stat_d = (chk_q == 32'd0) ? STAT_OK : STAT_BAD;
                      end
                    end else begin
                      acc_d   = '0;
                      fbits_d = 4'd8;
                    end
                  end
                  default: cmd_d = C_IDLE;
                endcase
              end
            end
          endcase
        end
      end

      S_CPRD: begin
        state_d = S_CPWR;
      end

      S_CPWR: begin
        if (!put_stall) begin
          put_en  = 1'b1;
          put_val = (off_q != 12'd0) ? ring_rdata : '0;
          run_d   = run_q - 9'd1;
          if (run_q == 9'd1) begin
            cmd_d   = C_IDLE;
            state_d = S_BITS;
            if (left_q == 32'd1) begin
              stat_d = (chk_q == 32'd0) ? STAT_OK : STAT_BAD;
            end
          end else begin
            state_d = S_CPRD;
          end
        end
      end

      S_FIN: begin
        if (stat_q == STAT_RUN && at_limit) begin
          stat_d = STAT_EXH;
        end
        state_d = S_END;
      end

      S_END: begin
        if (lanes_q != 4'd0 || stat_q != STAT_RUN) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
          end
        end
        if (emit || (lanes_q == 4'd0 && stat_q == STAT_RUN)) begin
          lbuf_d  = '0;
          lanes_d = '0;
          frz_d   = 1'b0;
          rcnt_d  = '0;
          state_d = S_WAIT;
        end
      end

      default: state_d = S_WAIT;
    endcase

    // Byte output: window write plus lane packing.
    if (put_en) begin
      ring_we    = 1'b1;
      ring_waddr = pos[AW-1:0];
      ring_wdata = put_val;
      left_d     = left_q - 32'd1;
      if (lanes_q == LANES) begin
        if (emit_need) begin
          emit    = 1'b1;
          rcnt_d  = rcnt_q + 6'd1;
          lbuf_d  = {56'd0, put_val};
          lanes_d = 4'd1;
        end else begin
          frz_d = 1'b1;
        end
      end else begin
        lbuf_d[8*lanes_q[2:0] +: 8] = put_val;
        lanes_d = lanes_q + 4'd1;
      end
    end
  end

  blz_ring #(
    .Depth (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      packed_q <= '0;
      cap_q    <= '0;
      chunk_q  <= '0;
      chk_q    <= '0;
      left_q   <= '0;
      hdr_q    <= '0;
      taken_q  <= '0;
      cmd_q    <= C_IDLE;
      acc_q    <= '0;
      fbits_q  <= '0;
      run_q    <= '0;
      off_q    <= '0;
      lbuf_q   <= '0;
      lanes_q  <= '0;
      frz_q    <= 1'b0;
      rcnt_q   <= '0;
      stat_q   <= STAT_RUN;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      chunk_q <= chunk_d;
      chk_q   <= chk_d;
      left_q  <= left_d;
      hdr_q   <= hdr_d;
      taken_q <= taken_d;
      cmd_q   <= cmd_d;
      acc_q   <= acc_d;
      fbits_q <= fbits_d;
      run_q   <= run_d;
      off_q   <= off_d;
      lbuf_q  <= lbuf_d;
      lanes_q <= lanes_d;
      frz_q   <= frz_d;
      rcnt_q  <= rcnt_d;
      stat_q  <= stat_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PACKED: packed_q <= cfg_data_i;
          CFG_CAP:    cap_q    <= cfg_data_i;
          default:    packed_q <= packed_q;
        endcase
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output payload register; the status goes out only on a word's last result.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q <= emit_bytes;
      oc_q <= emit_cnt;
      ol_q <= emit_last;
      os_q <= emit_last ? stat_d : STAT_RUN;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_bytes_o     = ob_q;
  assign byte_count_o    = oc_q;
  assign last_of_run_o   = ol_q;
  assign stream_status_o = os_q;

endmodule

`default_nettype wire

FILE: bench/backward_lz_bitstream_unpacker_core_tb.sv
// Testbench for the backward LZ bit-stream unpacker core.
// Depends on blz_pkg and the core RTL. It predicts every result with a scoreboard
// class, drives the word and configuration ports with plain tasks and ready in a process.
`default_nettype none

module backward_lz_bitstream_unpacker_core_tb import blz_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN       = DEF_WINDOW_DEPTH;
  localparam int unsigned LANES     = DEF_OUT_LANES;
  localparam int          MAX_GROUPS = 64;
  // Settling time after the last expected result; it covers a busy decoder.
  localparam int          SETTLE    = 1200;
  // Cycles without any transfer before the run is declared hung. The clearing
  // pass after reset and the long receiver hold both fit well inside it.
  localparam int          STALL_LIMIT = 20000;
  // Length of the long receiver hold.
  localparam int          HOLD_CYCLES = 600;

  // Decoder command states.
  typedef enum int {
    CMD_IDLE, CMD_PFX0, CMD_PFX1, CMD_RAWLEN3, CMD_OFF8,
    CMD_RAWLEN8, CMD_OFFSET, CMD_LEN8, CMD_RAW
  } cmd_e;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic [2:0]  status;
  } group_t;

  // Scoreboard: keeps its own copy of the decoder and the window, and queues
  // the lane groups that each accepted word should produce.
  class unpack_scoreboard;
    logic [31:0] packed_len, capacity;
    byte_t       window [WIN];
    logic [31:0] chunk, check, left, taken, run;
    int          phase, fbits, nl, nres;
    cmd_e        cmd;
    logic [11:0] acc, offs;
    logic [63:0] lanes;
    logic [2:0]  stat;
    group_t      groups [$];
    int          errors;

    function new();
      packed_len = 0; capacity = 0;
      foreach (window[i]) window[i] = 8'h00;
      chunk = 0; check = 0; left = 0; taken = 0; run = 0;
      phase = 0; fbits = 0; nl = 0; nres = 0;
      cmd = CMD_IDLE; acc = 0; offs = 0; lanes = 0;
      stat = STAT_RUN; errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_PACKED) packed_len = val;
      else capacity = val;
    endfunction

    function int pending();
      return groups.size();
    endfunction

    // Groups beyond the per-word budget are decoded but never reported.
    function void flush_group();
      group_t g;
      if (nres < MAX_GROUPS) begin
        g.bytes = lanes; g.count = nl[3:0]; g.last = 1'b0; g.status = STAT_RUN;
        groups = {groups, g};
        nres++;
      end
      lanes = 0;
      nl = 0;
    endfunction

    function void put_byte(logic [7:0] b);
      window[(left - 1) % WIN] = b;
      left--;
      lanes |= 64'(b) << (8 * nl);
      nl++;
      if (nl >= LANES) flush_group();
    endfunction

    function void begin_field(cmd_e st, int nbits);
      cmd = st;
      acc = 0;
      fbits = nbits;
    endfunction

    function void end_cmd();
      cmd = CMD_IDLE;
      if (left == 0) stat = (check == 0) ? STAT_OK : STAT_BAD;
    endfunction

    function void start_raw(logic [31:0] n);
      if ((left - 1) >= capacity || n > left) begin
        stat = STAT_BND;
        return;
      end
      run = n;
      begin_field(CMD_RAW, 8);
    endfunction

    function void copy_run();
      logic [31:0] p;
      logic [7:0]  b;
      if ({32'd0, left - 32'd1} + 64'(offs) >= {32'd0, capacity} || run > left) begin
        stat = STAT_BND;
        return;
      end
      while (run != 0) begin
        p = left - 1;
        b = 8'h00;
        // Distance zero reads the position about to be written, hence zero.
        if (offs != 0) b = window[(p + 32'(offs)) % WIN];
        put_byte(b);
        run--;
      end
      end_cmd();
    endfunction

    function void feed_bit(logic b);
      logic [11:0] v;
      if (cmd == CMD_IDLE) begin
        if (b) begin_field(CMD_PFX1, 2);
        else cmd = CMD_PFX0;
        return;
      end
      if (cmd == CMD_PFX0) begin
        if (b) begin_field(CMD_OFF8, 8);
        else begin_field(CMD_RAWLEN3, 3);
        return;
      end
      acc = {acc[10:0], b};
      if (fbits != 0) fbits--;
      if (fbits != 0) return;
      v = acc;
      case (cmd)
        CMD_PFX1: begin
          if (v == 3) begin_field(CMD_RAWLEN8, 8);
          else if (v < 2) begin
            run = 32'(v) + 3;
            begin_field(CMD_OFFSET, int'(v) + 9);
          end else begin_field(CMD_LEN8, 8);
        end
        CMD_RAWLEN3: start_raw(32'(v) + 1);
        CMD_RAWLEN8: start_raw(32'(v) + 9);
        CMD_OFF8: begin
          run = 2;
          offs = v;
          copy_run();
        end
        CMD_LEN8: begin
          run = 32'(v) + 1;
          begin_field(CMD_OFFSET, 12);
        end
        CMD_OFFSET: begin
          offs = v;
          copy_run();
        end
        CMD_RAW: begin
          put_byte(v[7:0]);
          if (run != 0) run--;
          if (run == 0) end_cmd();
          else begin_field(CMD_RAW, 8);
        end
        default: cmd = CMD_IDLE;
      endcase
    endfunction

    function void drain_chunk();
      while (stat == STAT_RUN && (chunk >> 1) != 0) begin
        logic b;
        b = chunk[0];
        chunk = chunk >> 1;
        feed_bit(b);
      end
    endfunction

    // Called for every word transfer; queues the groups it should produce.
    function void note_word(logic [31:0] w);
      group_t g;
      logic [31:0] limit;
      limit = packed_len >> 2;
      nres = 0;
      lanes = 0;
      nl = 0;
      if (stat != STAT_RUN) begin
        g.bytes = 0; g.count = 0; g.last = 1'b1; g.status = stat;
        groups = {groups, g};
        return;
      end
      if (taken >= limit) stat = STAT_EXH;
      else begin
        taken++;
        if (phase == 0) begin
          left = w;
          phase = 1;
        end else if (phase == 1) begin
          check = w;
          phase = 2;
        end else if (phase == 2) begin
          check ^= w;
          chunk = w;
          phase = 3;
          if (left == 0) stat = (check == 0) ? STAT_OK : STAT_BAD;
          else drain_chunk();
        end else begin
          check ^= w;
          chunk = (w >> 1) | CHUNK_MARK;
          feed_bit(w[0]);
          drain_chunk();
        end
        if (stat == STAT_RUN && taken >= limit) stat = STAT_EXH;
      end
      if (nl != 0) flush_group();
      if (nres == 0 && stat != STAT_RUN) begin
        g.bytes = 0; g.count = 0; g.last = 1'b0; g.status = STAT_RUN;
        groups = {groups, g};
        nres = 1;
      end
      if (nres > 0) begin
        groups[groups.size() - 1].last   = 1'b1;
        groups[groups.size() - 1].status = stat;
      end
    endfunction

    function void check_result(logic [63:0] bytes, logic [3:0] count, logic last,
                               logic [2:0] status);
      group_t g;
      if (groups.size() == 0) begin
        $error("unexpected result: out_bytes %h byte_count %0d", bytes, count);
        errors++;
        return;
      end
      g = groups.pop_front();
      if (bytes !== g.bytes) begin
        $error("out_bytes: expected %h, actual %h", g.bytes, bytes);
        errors++;
      end
      if (count !== g.count) begin
        $error("byte_count: expected %0d, actual %0d", g.count, count);
        errors++;
      end
      if (last !== g.last) begin
        $error("last_of_run: expected %0d, actual %0d", g.last, last);
        errors++;
      end
      if (status !== g.status) begin
        $error("stream_status: expected %0d, actual %0d", g.status, status);
        errors++;
      end
    endfunction
  endclass

  // All inputs of the block hold known values from time zero.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [31:0] word_in   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready, out_valid, last_of_run;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic [2:0]  stream_status;

  unpack_scoreboard sb;
  int tx_idle;
  int rx_idle;
  int hold_req = 0;
  int hold_seen;
  int hold_left;
  int quiet = 0;

  backward_lz_bitstream_unpacker_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .word_in_i      (word_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_bytes_o    (out_bytes),
    .byte_count_o   (byte_count),
    .last_of_run_o  (last_of_run),
    .stream_status_o(stream_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver side. A long hold, requested by the stimulus, keeps ready low so
  // that the block fills up and stops taking words. The hold is counted here.
  initial begin
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Transfers are sampled at the clock edge, where every signal still holds
  // its value from before the edge. A result is checked before the word of the
  // same edge is noted, since a word never produces a result at its own edge.
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result(out_bytes, byte_count, last_of_run, stream_status);
    if (in_valid && in_ready) sb.note_word(word_in);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offers one word and holds it until its transfer. Valid is only lowered
  // when the sender decides to idle, so back-to-back words keep it high.
  task automatic send_word(logic [31:0] w);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    word_in  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pauses until every expected result has come, then lets the block
  // settle, since a word may still be decoding without having produced any.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send_word($urandom());
  endtask

  initial begin
    logic [31:0] directed [$];
    sb = new();
    tx_idle = 35;
    rx_idle = 59;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Writes are accepted during the clearing pass.
    cfg_write(CFG_PACKED, 32'hFFFF_FFFF);
    cfg_write(CFG_CAP, 32'hFFFF_FFFF);

    // Header: the length is large enough that the stream never ends by itself,
    // then a check word and the first chunk.
    directed = '{32'h0010_0000, $urandom(), 32'hFFFF_FFFF, 32'h0000_0000,
                 32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'hC000_0003};
    foreach (directed[i]) send_word(directed[i]);
    send_random(60);

    // Long receiver hold while the sender keeps offering words.
    hold_req++;
    send_random(70);
    drain();

    cfg_write(CFG_CAP, 32'h8000_0000);
    cfg_write(CFG_PACKED, 32'h8000_0000);
    tx_idle = 59;
    rx_idle = 35;
    send_random(130);
    drain();

    cfg_write(CFG_CAP, 32'hFFFF_FFFF);
    tx_idle = 0;
    rx_idle = 0;
    send_random(130);
    drain();

    // Zero capacity makes the next command a bounds error; later words only
    // report the final status.
    cfg_write(CFG_CAP, 32'h0000_0000);
    tx_idle = 35;
    rx_idle = 59;
    send_random(10);
    drain();

    cfg_write(CFG_PACKED, 32'h0000_0000);
    send_random(4);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/blz_pkg.sv
hw/rtl/blz_ring.sv
hw/rtl/backward_lz_bitstream_unpacker_core.sv
bench/backward_lz_bitstream_unpacker_core_tb.sv
